[sv/ats_pkg.sv]
// Package for the assignment trail stack: payload structs, action and status codes,
// and the types passed along the chain of storage cells. No dependencies.
package ats_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned DepthW = 11;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] key;
    logic            push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found_value;
    logic [DepthW-1:0] depth;
  } out_item_t;

  // One stack entry as held by a cell.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            value;
  } entry_t;

  // Search token that walks from the top cell toward the bottom cell.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            hit;
    logic            value;
  } token_t;

  // Shift command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_cmd_t;

endpackage

[sv/assignment_trail_stack.sv]
// Top level of the assignment trail stack: a chain of DEPTH storage cells, the
// entry counter and the result register. Depends on ats_pkg and ats_cell.
//
// Usage. Items arrive on the in channel (in_valid_i / in_ready_o / in_data_i) and
// each one produces exactly one result on the out channel (out_valid_o /
// out_ready_i / out_data_o). Every transfer is a valid and ready handshake.
//
// The stack lives in a row of DEPTH identical cells. The top entry sits in the
// first cell. A push shifts every entry one cell deeper and writes the new pair
// into the first cell; a pop shifts every entry one cell up. Both finish in the
// cycle of the transfer, and their result is registered, valid in the next cycle.
//
// A lookup injects a search token into the first cell. The token moves one cell
// per cycle toward the bottom, and every cell holding a matching key overwrites
// the token's result, so the token leaves the last cell carrying the value of the
// oldest match. A lookup's result is registered from the token that leaves the last
// cell, so its wait is set by the length of the cell chain.
//
// One item is worked on at a time. A new item is taken when the block is idle and
// the result register is empty or being emptied in the same cycle. When the
// receiver stalls, the result stays in the result register and further input
// waits. Reset empties the stack and the result register and clears every cell.
module assignment_trail_stack #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ats_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ats_pkg::out_item_t out_data_o
);
  import ats_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  entry_t           ent   [DEPTH];
  token_t           tok   [DEPTH+1];
  entry_t           push_entry;
  entry_t           empty_entry;
  shift_cmd_t       cmd;
  logic             accept;
  logic             is_full;
  logic             is_empty;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // Input is taken only while idle and with room in the result register.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd.push = accept && (in_data_i.action == ACT_PUSH) && !is_full;
  assign cmd.pop  = accept && (in_data_i.action == ACT_POP) && !is_empty;

  assign push_entry.valid = 1'b1;
  assign push_entry.key   = in_data_i.key;
  assign push_entry.value = in_data_i.push_value;

  assign empty_entry = '0;

  // The search token enters the first cell at the transfer of a lookup.
  assign tok[0].valid = accept && (in_data_i.action == ACT_LOOKUP);
  assign tok[0].key   = in_data_i.key;
  assign tok[0].hit   = 1'b0;
  assign tok[0].value = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ats_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .up_i   ((i == 0) ? push_entry : ent[(i == 0) ? 0 : i - 1]),
      .down_i ((i == DEPTH - 1) ? empty_entry : ent[(i == DEPTH - 1) ? i : i + 1]),
      .ent_o  (ent[i]),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            out_data_q.found_value <= 1'b0;
            out_data_q.status      <= ST_OK;
            out_data_q.depth       <= DepthW'(count_q);
            case (in_data_i.action)
              ACT_PUSH: begin
                out_valid_q <= 1'b1;
                if (is_full) begin
                  out_data_q.status <= ST_FULL;
                end else begin
                  count_q          <= count_q + 1'b1;
                  out_data_q.depth <= DepthW'(count_q + 1'b1);
                end
              end
              ACT_POP: begin
                out_valid_q <= 1'b1;
                if (is_empty) begin
                  out_data_q.status <= ST_EMPTY;
                end else begin
                  count_q          <= count_q - 1'b1;
                  out_data_q.depth <= DepthW'(count_q - 1'b1);
                end
              end
              ACT_LOOKUP: begin
                state_q <= StScan;
              end
              default: begin
                // Unused action code: report ok with the depth unchanged.
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        StScan: begin
          // The result register is known to be empty here: it was free at the
          // lookup transfer and nothing else loads it during the scan.
          if (tok[DEPTH].valid) begin
            out_valid_q            <= 1'b1;
            out_data_q.status      <= tok[DEPTH].hit ? ST_OK : ST_MISSING;
            out_data_q.found_value <= tok[DEPTH].hit & tok[DEPTH].value;
            out_data_q.depth       <= DepthW'(count_q);
            state_q                <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[sv/ats_cell.sv]
// One storage cell of the assignment trail stack chain.
// Holds one entry and one search token stage; depends on ats_pkg.
module ats_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ats_pkg::shift_cmd_t cmd_i,
  input  ats_pkg::entry_t    up_i,
  input  ats_pkg::entry_t    down_i,
  output ats_pkg::entry_t    ent_o,
  input  ats_pkg::token_t    tok_i,
  output ats_pkg::token_t    tok_o
);
  import ats_pkg::*;

  entry_t ent_d, ent_q;
  token_t tok_d, tok_q;

  // A push moves every entry one cell deeper; a pop moves every entry one cell up.
  always_comb begin
    ent_d = ent_q;
    if (cmd_i.push) begin
      ent_d = up_i;
    end else if (cmd_i.pop) begin
      ent_d = down_i;
    end
  end

  // Deeper cells hold older entries, so a later hit overrides an earlier one.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && ent_q.valid && (ent_q.key == tok_i.key)) begin
      tok_d.hit   = 1'b1;
      tok_d.value = ent_q.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign ent_o = ent_q;
  assign tok_o = tok_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for assignment_trail_stack: a directed table followed by random
// trail traffic, results checked against typed values or a behavioral stack model. Uses ats_pkg.
module testbench;
  import ats_pkg::*;

  localparam int unsigned TRAIL_DEPTH = 1024;
  // Action code 3 is unused; the block must treat it as a no-op.
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  // A lookup keeps the block busy with no transfer at all while its token walks the cell
  // chain, and the long receiver hold-off adds to that. The watchdog limit is well above both.
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = TRAIL_DEPTH + 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  // Keys are mostly drawn from a small pool so that lookups hit and duplicates occur.
  localparam int unsigned KEY_POOL     = 32;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  assignment_trail_stack #(
    .DEPTH(TRAIL_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Our own copy of the trail. Index 0 is the bottom, the oldest entry.
  logic [KeyW-1:0] trail_keys [TRAIL_DEPTH];
  logic            trail_vals [TRAIL_DEPTH];
  int unsigned     trail_depth = 0;

  out_item_t   pending_results [$];
  stim_row_t   stim_rows [$];
  int unsigned fail_count     = 0;
  int unsigned result_index   = 0;
  int unsigned random_count   = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned sender_idle    = 0;
  int unsigned receiver_stall = 0;
  logic        hold_request   = 1'b0;

  always #1 clk_i = ~clk_i;

  // Applies one action to the trail copy and returns the result the block must give.
  function automatic out_item_t trail_apply(in_item_t item);
    out_item_t res;
    res = '0;
    res.status = ST_OK;
    case (item.action)
      ACT_PUSH: begin
        if (trail_depth >= TRAIL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          trail_keys[trail_depth] = item.key;
          trail_vals[trail_depth] = item.push_value;
          trail_depth++;
        end
      end
      ACT_POP: begin
        if (trail_depth == 0) res.status = ST_EMPTY;
        else trail_depth--;
      end
      ACT_LOOKUP: begin
        // Scan from the bottom so that the oldest of several duplicates wins.
        res.status = ST_MISSING;
        for (int unsigned i = 0; i < trail_depth; i++) begin
          if (trail_keys[i] == item.key) begin
            res.status      = ST_OK;
            res.found_value = trail_vals[i];
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.depth = DepthW'(trail_depth);
    return res;
  endfunction

  function automatic in_item_t make_item(logic [1:0] act, logic [KeyW-1:0] key, logic val);
    in_item_t item;
    item.action     = act;
    item.key        = key;
    item.push_value = val;
    return item;
  endfunction

  function automatic void add_row(logic [1:0] act, logic [KeyW-1:0] key, logic val,
                                  logic typed, logic [1:0] st, logic fv, int unsigned dp);
    stim_row_t row;
    row.stim             = make_item(act, key, val);
    row.typed            = typed;
    row.want.status      = st;
    row.want.found_value = fv;
    row.want.depth       = DepthW'(dp);
    stim_rows.push_back(row);
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, KEY_POOL - 1);
    if (r < 80) return (r % 2 == 0) ? '1 : '0;
    return $urandom();
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
             result_index, what, got, want);
    fail_count++;
  endtask

  // Offers one item and returns at the edge where its transfer happens. The idle gap,
  // if any, comes before the item, so valid is never dropped and raised in one step.
  // A row with a typed result queues that result; all others queue the prediction.
  task automatic send_item(in_item_t item, logic typed, out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = 0;
    while (sender_idle != 0 && $urandom_range(0, 99) < sender_idle && gap < 64) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = trail_apply(item);
    pending_results.push_back(typed ? want : predicted);
    if (item.action != ACT_UNUSED) random_count++;
  endtask

  task automatic send_random(in_item_t item);
    send_item(item, 1'b0, '0);
  endtask

  // One decision level of a solver: a few assignments pushed, a few variables looked up,
  // then a backtrack that may pop more than was pushed.
  task automatic run_decision();
    int unsigned pushes;
    int unsigned looks;
    int unsigned pops;
    pushes = $urandom_range(1, 6);
    looks  = $urandom_range(0, 2);
    pops   = $urandom_range(0, pushes + 1);
    repeat (pushes) send_random(make_item(ACT_PUSH, pick_key(), 1'($urandom)));
    repeat (looks) send_random(make_item(ACT_LOOKUP, pick_key(), 1'($urandom)));
    repeat (pops) send_random(make_item(ACT_POP, $urandom(), 1'($urandom)));
  endtask

  // Mostly decision levels; one step in ten is a lone item of any action, unused code too.
  task automatic run_random_phase(int unsigned target);
    while (random_count < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random(make_item(2'($urandom_range(0, 3)), $urandom(), 1'($urandom)));
      end else begin
        run_decision();
      end
    end
  endtask

  // The receiver stalls at random, except for one long hold-off that the stimulus asks
  // for. The hold-off is counted here, so the sender keeps offering items meanwhile and
  // the block has to stall its input once its result register is full.
  initial begin : receiver
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request <= 1'b0;
        out_ready_i  <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= receiver_stall);
      end
    end
  end

  // Every result transfer is checked against the oldest pending result, field by field.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_data_o), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        if (out_data_o.found_value !== want.found_value)
          report_mismatch("found_value", 32'(out_data_o.found_value),
                          32'(want.found_value));
        if (out_data_o.depth !== want.depth)
          report_mismatch("depth", 32'(out_data_o.depth), 32'(want.depth));
      end
      result_index++;
    end
  end

  // Watchdog: ends the run when no transfer of either kind has happened for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;

    // Directed rows. Results are typed in where they follow at once from the action:
    // the empty trail after reset, the key extremes, duplicates and the unused code.
    add_row(ACT_POP,    32'h0000_0000, 1'b0, 1'b1, ST_EMPTY,   1'b0, 0);
    add_row(ACT_LOOKUP, 32'h0000_0000, 1'b0, 1'b1, ST_MISSING, 1'b0, 0);
    add_row(ACT_UNUSED, 32'h0000_0000, 1'b0, 1'b1, ST_OK,      1'b0, 0);
    add_row(ACT_PUSH,   32'h0000_0000, 1'b1, 1'b1, ST_OK,      1'b0, 1);
    add_row(ACT_PUSH,   32'hFFFF_FFFF, 1'b0, 1'b1, ST_OK,      1'b0, 2);
    add_row(ACT_LOOKUP, 32'h0000_0000, 1'b0, 1'b1, ST_OK,      1'b1, 2);
    add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK,      1'b0, 2);
    // A duplicate key: the lookup must still return the older value.
    add_row(ACT_PUSH,   32'h0000_0000, 1'b0, 1'b1, ST_OK,      1'b0, 3);
    add_row(ACT_LOOKUP, 32'h0000_0000, 1'b0, 1'b1, ST_OK,      1'b1, 3);
    add_row(ACT_LOOKUP, 32'h7FFF_FFFF, 1'b0, 1'b1, ST_MISSING, 1'b0, 3);
    add_row(ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK,      1'b0, 3);
    add_row(ACT_PUSH,   32'h8000_0000, 1'b1, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_PUSH,   32'hAAAA_AAAA, 1'b1, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_PUSH,   32'h5555_5555, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_LOOKUP, 32'h8000_0000, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_LOOKUP, 32'h5555_5555, 1'b1, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_POP,    32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_LOOKUP, 32'h5555_5555, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_POP,    32'h0000_0000, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_POP,    32'h0000_0000, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_POP,    32'h0000_0000, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_POP,    32'h0000_0000, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_POP,    32'h0000_0000, 1'b0, 1'b0, ST_OK,      1'b0, 0);
    add_row(ACT_POP,    32'hFFFF_FFFF, 1'b1, 1'b1, ST_EMPTY,   1'b0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle    = 14;
    receiver_stall = 14;
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_item(row.stim, row.typed, row.want);
    end
    random_count = 0;

    // No idling at all, plus the long receiver hold-off while items keep coming.
    sender_idle    = 0;
    receiver_stall = 0;
    hold_request  <= 1'b1;
    run_random_phase(80);

    sender_idle    = 77;
    receiver_stall = 0;
    run_random_phase(160);

    sender_idle    = 0;
    receiver_stall = 77;
    run_random_phase(240);

    sender_idle    = 14;
    receiver_stall = 14;
    run_random_phase(300);

    // Push a few more pairs, search the trail, send the unused code, work a few decision
    // levels on top of it, then unwind it all and pop the empty trail.
    repeat (4) send_random(make_item(ACT_PUSH, $urandom(), 1'($urandom)));
    send_random(make_item(ACT_LOOKUP, pick_key(), 1'b0));
    send_random(make_item(ACT_LOOKUP, $urandom(), 1'b1));
    send_random(make_item(ACT_UNUSED, $urandom(), 1'($urandom)));
    repeat (3) run_decision();
    while (trail_depth != 0) send_random(make_item(ACT_POP, $urandom(), 1'($urandom)));
    repeat (2) send_random(make_item(ACT_POP, $urandom(), 1'($urandom)));

    run_random_phase(450);
    in_valid_i <= 1'b0;

    // Wait for every pending result, then long enough for a lookup to come out, so a
    // stray extra result would still be caught.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
